[rtl/triggered_multichannel_capture_buffer_unit_macros.svh]
// assertion macros for the capture buffer checker
`ifndef TRIGGERED_MULTICHANNEL_CAPTURE_BUFFER_UNIT_MACROS_SVH
`define TRIGGERED_MULTICHANNEL_CAPTURE_BUFFER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TMCB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmcb check failed");

// next-cycle implication, sampled on clk, off during reset
`define TMCB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmcb check failed");

`endif

[rtl/tmcb_pkg.sv]
// shared constants, types and helpers of the capture buffer
package tmcb_pkg;

    localparam int CHANNELS   = 4;
    localparam int DEPTH      = 1024;
    localparam int DONE_COUNT = 64;
    localparam int COUNT_MAX  = 127;
    localparam int WIN_RESET  = 1024;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int MEM_DEPTH = CHANNELS * DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int CMD_W  = 3;
    localparam int CHAN_W = 4;
    localparam int SMP_W  = 16;
    localparam int RUN_W  = 11;
    localparam int POS_W  = 10;
    localparam int WIN_W  = 11;
    localparam int CNT_W  = 7;
    localparam int SUM_W  = 32;
    localparam int NUM_W  = 32;
    localparam int STEP_W = $clog2(NUM_W);

    localparam logic [CMD_W-1:0] CMD_LOG   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ARM   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TRIG  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WAVG  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TAVG  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd6;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_WSUM,
        ST_DRAIN,
        ST_START,
        ST_DIV,
        ST_RDMEM
    } state_t;

    typedef enum logic [1:0] {
        OSRC_ZERO,
        OSRC_QUOT,
        OSRC_MEM
    } out_src_t;

    typedef struct packed {
        logic     take;
        logic     sweep_clr;
        logic     init_wr;
        logic     clr_wr;
        logic     rd_sweep;
        logic     div_start;
        logic     idx_wr;
        logic     rd_issue;
        logic     load_out;
        out_src_t out_src;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] in_op;
        logic             in_ch_ok;
        logic             in_slow_wrap;
        logic             in_pt_nz;
        logic [CMD_W-1:0] op;
        logic             init_last;
        logic             row_last;
        logic             win_last;
        logic             div_done;
        logic             out_free;
    } dp_stat_t;

    function automatic logic [ADDR_W-1:0] row_addr(input logic [CH_W-1:0] ch,
                                                    input logic [IDX_W-1:0] idx);
        return ADDR_W'(ch) * ADDR_W'(DEPTH) + ADDR_W'(idx);
    endfunction

endpackage

[rtl/tmcb_if.sv]
// valid/ready channel interfaces for commands and results
interface tmcb_in_if;
    import tmcb_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [CHAN_W-1:0]        channel;
    logic signed [SMP_W-1:0]  sample;
    logic [RUN_W-1:0]         count;
    logic [POS_W-1:0]         position;
    modport source (output valid, cmd, channel, sample, count, position, input ready);
    modport sink   (input valid, cmd, channel, sample, count, position, output ready);
endinterface

interface tmcb_out_if;
    import tmcb_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [SMP_W-1:0]  value;
    logic                     capture_done;
    logic                     armed;
    modport source (output valid, value, capture_done, armed, input ready);
    modport sink   (input valid, value, capture_done, armed, output ready);
endinterface

[rtl/triggered_multichannel_capture_buffer_unit.sv]
// top level of the triggered multichannel capture buffer
//
//  channel  role    payload                                    transfer when
//  req      sink    cmd, channel, sample, count, position      req.valid && req.ready
//  rsp      source  value, capture_done, armed                 rsp.valid && rsp.ready
//  cfg      write   cfg_wdata = window_size                    cfg_we high
//
//  after reset a clearing pass zeroes the 4096-entry store, one cycle an entry, req.ready low
//  log, arm, trigger answer at once; a log whose slot wraps past twice the window answers at
//  once but keeps the block busy through the divider start, its 32 steps and done
//  clear sweeps the row; window average sums the window and divides; trigger average divides
//  one item at a time: req.ready is high only in idle with the result register empty
//  or read in that same cycle, so a waiting result holds off the next transfer
module triggered_multichannel_capture_buffer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    tmcb_in_if.sink                       req,
    tmcb_out_if.source                    rsp,
    input  logic                          cfg_we,
    input  logic [tmcb_pkg::WIN_W-1:0]    cfg_wdata
);
    import tmcb_pkg::*;

    // command and status between controller and datapath
    dp_cmd_t  cmd;
    dp_stat_t st;

    tmcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // store, per-channel counters and sums, divider, result register
    tmcb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .in_cmd      (req.cmd),
        .in_channel  (req.channel),
        .in_sample   (req.sample),
        .in_count    (req.count),
        .in_position (req.position),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .out_value   (rsp.value),
        .out_done    (rsp.capture_done),
        .out_armed   (rsp.armed)
    );

endmodule

[rtl/tmcb_div.sv]
// iterative signed-by-unsigned divider, one quotient bit per cycle
module tmcb_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [tmcb_pkg::NUM_W-1:0] num,
    input  logic [tmcb_pkg::WIN_W-1:0]        den,
    output logic                              done,
    output logic signed [tmcb_pkg::NUM_W-1:0] quot,
    output logic [tmcb_pkg::WIN_W-1:0]        rem
);
    import tmcb_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [WIN_W:0]    r_reg;
    logic [WIN_W-1:0]  den_reg;
    logic              neg_reg;
    logic [WIN_W:0]    r_try;
    logic              fits;

    assign r_try = {r_reg[WIN_W-1:0], q_reg[NUM_W-1]};
    assign fits  = r_try >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            r_reg   <= '0;
            den_reg <= den;
            neg_reg <= num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            r_reg <= fits ? r_try - {1'b0, den_reg} : r_try;
            q_reg <= {q_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);
    assign rem  = r_reg[WIN_W-1:0];

endmodule

[rtl/tmcb_dp.sv]
// datapath: sample store, per-channel state, accumulator, divider, output register
module tmcb_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tmcb_pkg::dp_cmd_t                 cmd,
    output tmcb_pkg::dp_stat_t                st,
    input  logic [tmcb_pkg::CMD_W-1:0]        in_cmd,
    input  logic [tmcb_pkg::CHAN_W-1:0]       in_channel,
    input  logic signed [tmcb_pkg::SMP_W-1:0] in_sample,
    input  logic [tmcb_pkg::RUN_W-1:0]        in_count,
    input  logic [tmcb_pkg::POS_W-1:0]        in_position,
    input  logic                              cfg_we,
    input  logic [tmcb_pkg::WIN_W-1:0]        cfg_wdata,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic signed [tmcb_pkg::SMP_W-1:0] out_value,
    output logic                              out_done,
    output logic                              out_armed
);
    import tmcb_pkg::*;

    logic [SMP_W-1:0] mem [MEM_DEPTH];
    logic [SMP_W-1:0] rdata_reg;

    logic [WIN_W-1:0] win_reg;
    logic [WIN_W-1:0] win;

    logic [IDX_W-1:0]        wr_idx_reg  [CHANNELS];
    logic [IDX_W-1:0]        wr_idx_next [CHANNELS];
    logic [CNT_W-1:0]        pt_cnt_reg  [CHANNELS];
    logic [CNT_W-1:0]        pt_cnt_next [CHANNELS];
    logic signed [SUM_W-1:0] pt_sum_reg  [CHANNELS];
    logic signed [SUM_W-1:0] pt_sum_next [CHANNELS];
    logic trig_reg, trig_next;
    logic log_reg, log_next;

    logic [CMD_W-1:0]  op_reg;
    logic [CHAN_W-1:0] ch_reg;
    logic [RUN_W-1:0]  cnt_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CH_W-1:0]   ch_idx;

    logic [ADDR_W-1:0] swp_reg;
    logic              acc_vld_reg;
    logic signed [SUM_W-1:0] acc_reg;

    logic              in_ok;
    logic [CH_W-1:0]   in_idx;
    logic [IDX_W-1:0]  wi_in;
    logic [WIN_W-1:0]  wrap_inc;
    logic              slow;
    logic [IDX_W-1:0]  wi_fast;
    logic              log_go;
    logic [CNT_W-1:0]  cnt_inc;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [SMP_W-1:0]  mem_wdata;

    logic                     div_done;
    logic signed [NUM_W-1:0]  div_num;
    logic [WIN_W-1:0]         div_den;
    logic signed [NUM_W-1:0]  div_quot;
    logic [WIN_W-1:0]         div_rem;
    logic [WIN_W-1:0]         c_eff;

    logic [CHAN_W-1:0] f_ch;
    logic              f_ok;
    logic [CH_W-1:0]   f_idx;

    // effective window: clamp to store depth, zero acts as one
    always_comb
    begin
        if (win_reg > WIN_W'(DEPTH))
            win = WIN_W'(DEPTH);
        else if (win_reg == '0)
            win = WIN_W'(1);
        else
            win = win_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= WIN_W'(WIN_RESET);
        else if (cfg_we)
            win_reg <= cfg_wdata;
    end

    assign in_ok    = int'(in_channel) < CHANNELS;
    assign in_idx   = in_channel[CH_W-1:0];
    assign wi_in    = wr_idx_reg[in_idx];
    assign wrap_inc = WIN_W'(wi_in) + WIN_W'(1);
    assign slow     = {1'b0, wrap_inc} >= {win, 1'b0};
    assign wi_fast  = (wrap_inc < win) ? wrap_inc[IDX_W-1:0]
                                       : IDX_W'(wrap_inc - win);
    assign log_go   = cmd.take && (in_cmd == CMD_LOG) && log_reg && in_ok;
    assign cnt_inc  = (pt_cnt_reg[in_idx] < CNT_W'(COUNT_MAX))
                      ? pt_cnt_reg[in_idx] + 1'b1 : pt_cnt_reg[in_idx];
    assign ch_idx   = ch_reg[CH_W-1:0];

    // per-channel and global state updates
    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        pt_cnt_next = pt_cnt_reg;
        pt_sum_next = pt_sum_reg;
        trig_next   = trig_reg;
        log_next    = log_reg;
        if (cmd.take)
        begin
            case (in_cmd)
                CMD_LOG:
                begin
                    if (log_reg && in_ok)
                    begin
                        if (!slow)
                            wr_idx_next[in_idx] = wi_fast;
                        if (trig_reg)
                        begin
                            pt_cnt_next[in_idx] = cnt_inc;
                            pt_sum_next[in_idx] = pt_sum_reg[in_idx] + SUM_W'(in_sample);
                            if (cnt_inc >= CNT_W'(DONE_COUNT))
                                log_next = 1'b0;
                        end
                    end
                end
                CMD_ARM:
                begin
                    trig_next = 1'b0;
                    log_next  = 1'b1;
                end
                CMD_TRIG:
                begin
                    trig_next = 1'b1;
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        pt_cnt_next[i] = '0;
                        pt_sum_next[i] = '0;
                    end
                end
                CMD_CLEAR:
                begin
                    if (in_ok)
                        wr_idx_next[in_idx] = '0;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.idx_wr)
            wr_idx_next[ch_idx] = div_rem[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                wr_idx_reg[i] <= '0;
                pt_cnt_reg[i] <= '0;
                pt_sum_reg[i] <= '0;
            end
            trig_reg    <= 1'b0;
            log_reg     <= 1'b0;
            swp_reg     <= '0;
            acc_vld_reg <= 1'b0;
            out_valid   <= 1'b0;
        end
        else
        begin
            wr_idx_reg  <= wr_idx_next;
            pt_cnt_reg  <= pt_cnt_next;
            pt_sum_reg  <= pt_sum_next;
            trig_reg    <= trig_next;
            log_reg     <= log_next;
            acc_vld_reg <= cmd.rd_sweep;
            if (cmd.sweep_clr)
                swp_reg <= '0;
            else if (cmd.init_wr || cmd.clr_wr || cmd.rd_sweep)
                swp_reg <= swp_reg + 1'b1;
            if (cmd.load_out)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    // captured item fields and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg  <= in_cmd;
            ch_reg  <= in_channel;
            cnt_reg <= in_count;
            pos_reg <= in_position;
            acc_reg <= '0;
        end
        else if (acc_vld_reg)
            acc_reg <= acc_reg + SUM_W'($signed(rdata_reg));
    end

    // sample store, one write and one registered read per cycle
    assign mem_we    = cmd.init_wr || cmd.clr_wr || log_go;
    assign mem_wdata = log_go ? in_sample : '0;

    always_comb
    begin
        if (cmd.init_wr)
            mem_waddr = swp_reg;
        else if (cmd.clr_wr)
            mem_waddr = row_addr(ch_idx, swp_reg[IDX_W-1:0]);
        else
            mem_waddr = row_addr(in_idx, wi_in);
    end

    assign mem_raddr = cmd.rd_issue ? row_addr(ch_idx, div_rem[IDX_W-1:0])
                                    : row_addr(ch_idx, swp_reg[IDX_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    // divider operands by operation
    assign c_eff = (WIN_W'(cnt_reg) > win) ? win : WIN_W'(cnt_reg);

    always_comb
    begin
        div_den = win;
        case (op_reg)
            CMD_LOG:  div_num = NUM_W'(wr_idx_reg[ch_idx]) + NUM_W'(1);
            CMD_TAVG:
            begin
                div_num = pt_sum_reg[ch_idx];
                div_den = WIN_W'(pt_cnt_reg[ch_idx]);
            end
            CMD_WAVG: div_num = acc_reg;
            CMD_READ: div_num = NUM_W'(wr_idx_reg[ch_idx]) + NUM_W'(pos_reg)
                                + NUM_W'(win) - NUM_W'(c_eff);
            default:  div_num = acc_reg;
        endcase
    end

    tmcb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    // output register, flags taken after the command
    assign f_ch  = cmd.take ? in_channel : ch_reg;
    assign f_ok  = int'(f_ch) < CHANNELS;
    assign f_idx = f_ch[CH_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            case (cmd.out_src)
                OSRC_QUOT: out_value <= div_quot[SMP_W-1:0];
                OSRC_MEM:  out_value <= rdata_reg;
                default:   out_value <= '0;
            endcase
            out_done  <= f_ok && trig_next && (pt_cnt_next[f_idx] >= CNT_W'(DONE_COUNT));
            out_armed <= log_next;
        end
    end

    assign st.in_op        = in_cmd;
    assign st.in_ch_ok     = in_ok;
    assign st.in_slow_wrap = log_reg && in_ok && slow;
    assign st.in_pt_nz     = pt_cnt_reg[in_idx] != '0;
    assign st.op           = op_reg;
    assign st.init_last    = swp_reg == ADDR_W'(MEM_DEPTH - 1);
    assign st.row_last     = swp_reg[IDX_W-1:0] == IDX_W'(DEPTH - 1);
    assign st.win_last     = WIN_W'(swp_reg[IDX_W-1:0]) == win - 1'b1;
    assign st.div_done     = div_done;
    assign st.out_free     = !out_valid || out_ready;

endmodule

[rtl/tmcb_ctrl.sv]
// controller state machine sequencing the datapath
module tmcb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tmcb_pkg::dp_stat_t st,
    output tmcb_pkg::dp_cmd_t  cmd
);
    import tmcb_pkg::*;

    state_t state_reg, state_next;
    logic   take;

    assign in_ready = (state_reg == ST_IDLE) && st.out_free;
    assign take     = in_ready && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (st.init_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    case (st.in_op)
                        CMD_LOG:
                        begin
                            if (st.in_slow_wrap)
                                state_next = ST_START;
                        end
                        CMD_CLEAR:
                        begin
                            if (st.in_ch_ok)
                                state_next = ST_CLEAR;
                        end
                        CMD_WAVG:
                        begin
                            if (st.in_ch_ok)
                                state_next = ST_WSUM;
                        end
                        CMD_TAVG:
                        begin
                            if (st.in_ch_ok && st.in_pt_nz)
                                state_next = ST_START;
                        end
                        CMD_READ:
                        begin
                            if (st.in_ch_ok)
                                state_next = ST_START;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (st.row_last)
                    state_next = ST_IDLE;
            end
            ST_WSUM:
            begin
                if (st.win_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (st.div_done)
                    state_next = (st.op == CMD_READ) ? ST_RDMEM : ST_IDLE;
            end
            ST_RDMEM: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.out_src = OSRC_ZERO;
        case (state_reg)
            ST_INIT:
                cmd.init_wr = 1'b1;
            ST_IDLE:
            begin
                cmd.take      = take;
                cmd.sweep_clr = take;
                if (take)
                begin
                    case (st.in_op)
                        CMD_CLEAR, CMD_WAVG, CMD_READ:
                            cmd.load_out = !st.in_ch_ok;
                        CMD_TAVG:
                            cmd.load_out = !(st.in_ch_ok && st.in_pt_nz);
                        default:
                            cmd.load_out = 1'b1;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_wr   = 1'b1;
                cmd.load_out = st.row_last;
            end
            ST_WSUM:
                cmd.rd_sweep = 1'b1;
            ST_START:
                cmd.div_start = 1'b1;
            ST_DIV:
            begin
                if (st.div_done)
                begin
                    case (st.op)
                        CMD_LOG:  cmd.idx_wr = 1'b1;
                        CMD_READ: cmd.rd_issue = 1'b1;
                        default:
                        begin
                            cmd.load_out = 1'b1;
                            cmd.out_src  = OSRC_QUOT;
                        end
                    endcase
                end
            end
            ST_RDMEM:
            begin
                cmd.load_out = 1'b1;
                cmd.out_src  = OSRC_MEM;
            end
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/tmcb_chk.sv]
// port-level checker for the capture buffer and its bind
`include "triggered_multichannel_capture_buffer_unit_macros.svh"

module tmcb_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [tmcb_pkg::CMD_W-1:0]   in_cmd,
    input logic [tmcb_pkg::CHAN_W-1:0]  in_channel,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         out_armed
);
    import tmcb_pkg::*;

    logic xfer_in;
    logic clr_take;

    assign xfer_in  = in_valid && in_ready;
    assign clr_take = xfer_in && in_cmd == CMD_CLEAR && int'(in_channel) < CHANNELS;

    // a waiting result is held
    `TMCB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
    // no transfer in while the result register is stalled full
    `TMCB_ASSERT_IMP(a_no_take_full, out_valid && !out_ready, !in_ready)
    // arm answers at once with armed set
    `TMCB_ASSERT_NXT(a_arm_result, xfer_in && in_cmd == CMD_ARM, out_valid && out_armed)
    // a clear of a real channel sweeps its row before the next transfer
    `TMCB_ASSERT_NXT(a_clear_busy, clr_take, !in_ready)

endmodule

bind triggered_multichannel_capture_buffer_unit tmcb_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_cmd     (req.cmd),
    .in_channel (req.channel),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_armed  (rsp.armed)
);
